// ===== rtl/core/sla_pkg.sv =====
`timescale 1ns / 1ps

package sla_pkg;

  localparam int LineBytes = 64;
  localparam int CellCount = LineBytes - 1;
  localparam int LenW      = $clog2(LineBytes);

  localparam logic [7:0] ByteCr    = 8'h0D;
  localparam logic [7:0] ByteLf    = 8'h0A;
  localparam logic [7:0] PrintLow  = 8'h20;
  localparam logic [7:0] PrintHigh = 8'h7E;

  localparam logic KindChar = 1'b0;
  localparam logic KindErr  = 1'b1;

  typedef enum logic {
    StIdle,
    StRead
  } state_e;

  // per-cycle commands from the controller to the cell row and output stage
  typedef struct packed {
    logic append;    // store the byte at the token cell, move token on
    logic shift;     // move every character one cell toward cell 0
    logic clear;     // token back to cell 0
    logic out_load;  // load the output register
    logic out_err;   // loaded result is a too-long error
    logic out_last;  // loaded result ends the run
  } ctrl_t;

endpackage

// ===== rtl/core/sla_cell.sv =====
`timescale 1ns / 1ps

module sla_cell import sla_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_t      ctrl_i,
  input  logic       first_i,     // tied high on cell 0 only
  input  logic [6:0] wr_char_i,
  input  logic       tok_i,       // token of the left neighbor
  input  logic [6:0] nxt_char_i,  // character of the right neighbor
  output logic       tok_o,
  output logic [6:0] char_o
);

  logic       tok_q, tok_d;
  logic [6:0] char_q, char_d;

  always_comb begin
    tok_d = tok_q;
    if (ctrl_i.clear) begin
      tok_d = first_i;
    end else if (ctrl_i.append) begin
      tok_d = tok_i;
    end
  end

  always_comb begin
    char_d = char_q;
    if (ctrl_i.append && tok_q) begin
      char_d = wr_char_i;
    end else if (ctrl_i.shift) begin
      char_d = nxt_char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= first_i;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign tok_o  = tok_q;
  assign char_o = char_q;

endmodule

// ===== rtl/core/sla_ctrl.sv =====
`timescale 1ns / 1ps

module sla_ctrl import sla_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  output logic       in_ready_o,
  input  logic       out_free_i,
  input  logic       full_i,      // token has run past the last cell
  output ctrl_t      ctrl_o
);

  state_e          state_q, state_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] rd_cnt_q, rd_cnt_d;
  logic            acc, is_lf, is_print, start_rd;

  assign in_ready_o = (state_q == StIdle) && out_free_i;
  assign acc        = in_valid_i && in_ready_o;
  assign is_lf      = (in_byte_i == ByteLf);
  assign is_print   = in_byte_i inside {[PrintLow:PrintHigh]};
  assign start_rd   = acc && is_lf && (len_q != '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start_rd) state_d = StRead;
      end
      StRead: begin
        if (out_free_i && rd_cnt_q == LenW'(1)) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    case (state_q)
      StIdle: begin
        ctrl_o.append   = acc && is_print && !full_i;
        ctrl_o.out_err  = acc && is_print && full_i;
        ctrl_o.out_load = ctrl_o.out_err;
        ctrl_o.out_last = ctrl_o.out_err;
        ctrl_o.clear    = ctrl_o.out_err || start_rd;
      end
      StRead: begin
        ctrl_o.shift    = out_free_i;
        ctrl_o.out_load = out_free_i;
        ctrl_o.out_last = (rd_cnt_q == LenW'(1));
      end
      default: ctrl_o = '0;
    endcase
  end

  always_comb begin
    len_d = len_q;
    if (ctrl_o.clear) begin
      len_d = '0;
    end else if (ctrl_o.append) begin
      len_d = len_q + LenW'(1);
    end
  end

  always_comb begin
    rd_cnt_d = rd_cnt_q;
    if (start_rd) begin
      rd_cnt_d = len_q;
    end else if (ctrl_o.shift) begin
      rd_cnt_d = rd_cnt_q - LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      len_q    <= '0;
      rd_cnt_q <= '0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      rd_cnt_q <= rd_cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_full_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_i == (len_q == LenW'(CellCount)))
    else $error("token position disagrees with line length");

  a_read_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> (rd_cnt_q != '0))
    else $error("readout running with zero count");

  a_err_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_err |=> (len_q == '0) && (state_q == StIdle))
    else $error("line not discarded after too-long error");

  a_no_append_rd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> !ctrl_o.append && !in_ready_o)
    else $error("byte taken during readout");
`endif

endmodule

// ===== rtl/core/serial_line_assembler_unit.sv =====
`timescale 1ns / 1ps

// Serial line assembler: takes one received byte per request and builds text
// lines. Printable bytes (0x20..0x7E) are kept in a row of 63 character cells;
// carriage return, other control bytes and bytes above 0x7E are dropped. A
// line feed on a non-empty line sends its characters out in order, tlast on the
// final one; an empty line sends nothing. A printable byte arriving on a full
// line (63 characters) discards the line and sends one error result (tuser 1,
// tdata 0, tlast 1). While idle a byte is taken every cycle the output register
// can accept; a line of n characters then holds off input while the cell row
// shifts one character to the output per cycle whenever the downstream side
// does not stall.
module serial_line_assembler_unit import sla_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] line_char, [7] zero
  output logic       m_axis_tuser,   // [0] kind
  output logic       m_axis_tlast    // last_of_run
);

  ctrl_t      ctrl;
  logic       out_free;
  logic       tok_w  [CellCount+1];
  logic [6:0] char_w [CellCount+1];

  logic       tok_end_q, tok_end_d;
  logic       vld_q, vld_d;
  logic       kind_q;
  logic [6:0] chr_q;
  logic       last_q;

  assign out_free = !vld_q || m_axis_tready;

  sla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .full_i     (tok_end_q),
    .ctrl_o     (ctrl)
  );

  assign tok_w[0]          = 1'b0;
  assign char_w[CellCount] = '0;

  for (genvar i = 0; i < CellCount; i++) begin : g_cell
    sla_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .first_i    (i == 0),
      .wr_char_i  (s_axis_tdata[6:0]),
      .tok_i      (tok_w[i]),
      .nxt_char_i (char_w[i+1]),
      .tok_o      (tok_w[i+1]),
      .char_o     (char_w[i])
    );
  end

  // token position past the last cell: line holds 63 characters
  always_comb begin
    tok_end_d = tok_end_q;
    if (ctrl.clear) begin
      tok_end_d = 1'b0;
    end else if (ctrl.append) begin
      tok_end_d = tok_w[CellCount];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_end_q <= 1'b0;
    end else begin
      tok_end_q <= tok_end_d;
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (ctrl.out_load) begin
      vld_d = 1'b1;
    end else if (m_axis_tready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      kind_q <= ctrl.out_err ? KindErr : KindChar;
      chr_q  <= ctrl.out_err ? 7'd0 : char_w[0];
      last_q <= ctrl.out_last;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {1'b0, chr_q};
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;

endmodule
